>>> src/dq_pkg.sv
// dq_pkg: shared widths, operation codes, status codes and default depth
// for the double-ended queue. No dependencies.
package dq_pkg;

  // payload widths
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // default number of entries
  localparam int unsigned DQ_DEPTH = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

>>> src/dq_mem.sv
// dq_mem: entry storage of the queue, one write port and one registered read port.
// Depends on dq_pkg for the value width.
module dq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [dq_pkg::VAL_W-1:0]    wr_data_i,
  input  logic                        rd_en_i,
  input  logic [IDX_W-1:0]            rd_addr_i,
  output logic [dq_pkg::VAL_W-1:0]    rd_data_o
);
  import dq_pkg::*;

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/double_ended_queue.sv
// double_ended_queue: bounded deque of signed 32-bit values, sequencer and output register.
// Depends on dq_pkg and dq_mem.
//
//   channel | direction | handshake             | fields
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o | operation_i, value_i
//   out     | output    | out_valid_o/out_stall_i| value_res_o, status_o, count_o, last_o
//
// A push or pop gives one beat. A list of N stored entries gives N beats, with
// one memory read per entry through the single read port and the first read
// issued in the accept cycle. The input stalls during a list walk
// and while an undelivered result is held by a stalled output.
// Reset (rst_ni low) empties the queue at once; the entry memory is not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dq_pkg::OP_W-1:0]          operation_i,
  input  logic signed [dq_pkg::VAL_W-1:0]  value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [dq_pkg::VAL_W-1:0]  value_res_o,
  output logic [dq_pkg::STATUS_W-1:0]      status_o,
  output logic [dq_pkg::COUNT_W-1:0]       count_o,
  output logic                             last_o
);
  import dq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   front_q, front_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   walk_q, walk_d;
  logic [CNT_W-1:0]   rem_q, rem_d;

  logic               out_valid_q, out_valid_d;
  logic [VAL_W-1:0]   out_value_q, out_value_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic               out_last_q, out_last_d;

  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic [IDX_W-1:0]   front_inc;
  logic [IDX_W-1:0]   front_dec;
  logic [IDX_W-1:0]   walk_inc;
  logic [IDX_W:0]     back_sum;
  logic [IDX_W-1:0]   back_idx;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VAL_W-1:0]   rd_data;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (fill_q == CNT_W'(DEPTH));
  assign empty = (fill_q == '0);

  // circular index arithmetic
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign walk_inc  = (walk_q == IDX_W'(DEPTH - 1)) ? '0 : walk_q + 1'b1;
  assign back_sum  = {1'b0, front_q} + (IDX_W + 1)'(fill_q);
  assign back_idx  = (back_sum >= (IDX_W + 1)'(DEPTH)) ?
                     IDX_W'(back_sum - (IDX_W + 1)'(DEPTH)) : back_sum[IDX_W-1:0];

  // sequencer
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    fill_d       = fill_q;
    walk_d       = walk_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    wr_addr      = back_idx;
    rd_en        = 1'b0;
    rd_addr      = front_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_value_d = '0;
          out_last_d  = 1'b1;
          case (operation_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_status_d = STAT_FULL;
                out_count_d  = COUNT_W'(fill_q);
              end else begin
                wr_en = 1'b1;
                if (operation_i == OP_PUSH_FRONT) begin
                  wr_addr = front_dec;
                  front_d = front_dec;
                end
                fill_d       = fill_q + 1'b1;
                out_status_d = STAT_OK;
                out_count_d  = COUNT_W'(fill_q + 1'b1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_status_d = STAT_EMPTY;
                out_count_d  = '0;
              end else begin
                if (operation_i == OP_POP_FRONT) begin
                  front_d = front_inc;
                end
                fill_d       = fill_q - 1'b1;
                out_status_d = STAT_OK;
                out_count_d  = COUNT_W'(fill_q - 1'b1);
              end
            end
            OP_LIST: begin
              if (empty) begin
                out_valid_d  = 1'b1;
                out_status_d = STAT_EMPTY;
                out_count_d  = '0;
              end else begin
                // first read goes out now, data lands next cycle
                rd_en   = 1'b1;
                rd_addr = front_q;
                walk_d  = front_q;
                rem_d   = fill_q - 1'b1;
                state_d = S_LIST;
              end
            end
            default: begin
              // unused codes: beat consumed, nothing emitted
            end
          endcase
        end
      end
      S_LIST: begin
        // one entry per free output slot, next read issued alongside
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = rd_data;
          out_status_d = STAT_OK;
          out_count_d  = COUNT_W'(fill_q);
          out_last_d   = (rem_q == '0);
          if (rem_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = walk_inc;
            walk_d  = walk_inc;
            rem_d   = rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk pointer, remaining count and output payload
  always_ff @(posedge clk_i) begin
    walk_q       <= walk_d;
    rem_q        <= rem_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  // entry storage
  dq_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;
  assign last_o      = out_last_q;

endmodule

>>> test/double_ended_queue_test.sv
// double_ended_queue_test: self-checking bench for the bounded deque, with a
// mirror of the queue that predicts every beat. Depends on dq_pkg and double_ended_queue.
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int unsigned SLOT_W = $clog2(DQ_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } reply_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [OP_W-1:0]             operation_i = OP_PUSH_FRONT;
  logic signed [VAL_W-1:0]     value_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [VAL_W-1:0]     value_res_o;
  logic [STATUS_W-1:0]         status_o;
  logic [COUNT_W-1:0]          count_o;
  logic                        last_o;

  // mirror of the queue contents
  logic signed [VAL_W-1:0] mirror_vals [DQ_DEPTH];
  int unsigned             mirror_head = 0;
  int unsigned             mirror_fill = 0;

  reply_t      reply_q [$];
  int unsigned fault_cnt = 0;
  bit          quiet     = 1'b0;

  double_ended_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_res_o (value_res_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -1;
      4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_push();
    return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  function automatic logic [OP_W-1:0] rand_pop();
    return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  // mirror slot for a position, wrapped around the depth
  function automatic slot_t slot_of(int unsigned pos);
    return slot_t'(pos % DQ_DEPTH);
  endfunction

  // apply one operation to the mirror and queue the beats it causes
  function automatic void deque_apply(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
    reply_t      r;
    int unsigned k;
    r = '{value_res: '0, status: STAT_OK, count: '0, last: 1'b1};
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (mirror_fill >= DQ_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            mirror_head = (mirror_head + DQ_DEPTH - 1) % DQ_DEPTH;
            mirror_vals[slot_of(mirror_head)] = val;
          end else begin
            mirror_vals[slot_of(mirror_head + mirror_fill)] = val;
          end
          mirror_fill++;
        end
        r.count = COUNT_W'(mirror_fill);
        reply_q.push_back(r);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (mirror_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) mirror_head = (mirror_head + 1) % DQ_DEPTH;
          mirror_fill--;
        end
        r.count = COUNT_W'(mirror_fill);
        reply_q.push_back(r);
      end
      OP_LIST: begin
        if (mirror_fill == 0) begin
          r.status = STAT_EMPTY;
          reply_q.push_back(r);
        end else begin
          for (k = 0; k < mirror_fill; k++) begin
            r.value_res = mirror_vals[slot_of(mirror_head + k)];
            r.count     = COUNT_W'(mirror_fill);
            r.last      = (k + 1 == mirror_fill);
            reply_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // compare one delivered beat with the oldest prediction
  function automatic void check_reply();
    reply_t want;
    if (reply_q.size() == 0) begin
      fault_cnt++;
      if (fault_cnt <= 10)
        $display("unexpected beat: value %0d status %0d count %0d last %0b",
                 value_res_o, status_o, count_o, last_o);
    end else begin
      want = reply_q.pop_front();
      if (value_res_o !== want.value_res || status_o !== want.status ||
          count_o !== want.count || last_o !== want.last) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("mismatch: expected value %0d status %0d count %0d last %0b,",
                   want.value_res, want.status, want.count, want.last,
                   " got value %0d status %0d count %0d last %0b",
                   value_res_o, status_o, count_o, last_o);
      end
    end
  endfunction

  // sample both channels mid-cycle, when every signal has settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) deque_apply(operation_i, value_i);
      if (out_valid_o && !out_stall_i) check_reply();
    end
  end

  // receiver stalls: free runs, then holds of random length
  initial begin
    int unsigned run_len;
    int unsigned hold_len;
    @(posedge rst_ni);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (run_len) begin
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      hold_len = gap_len();
      repeat (hold_len) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  // send one beat after an optional gap; returns at the accepting edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // hold off the sender until every predicted beat has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  // pops, lists and unused codes on an empty queue
  task automatic test_empty_queue();
    send_op(OP_POP_FRONT, rand_value());
    send_op(OP_POP_BACK, rand_value());
    send_op(OP_LIST, rand_value());
    send_op(OP_SPARE_LO, rand_value());
    send_op(OP_SPARE_HI, rand_value());
  endtask

  // extreme values at both ends, removal of the final element
  task automatic test_value_extremes();
    send_op(OP_PUSH_BACK, VAL_MAX);
    send_op(OP_PUSH_FRONT, VAL_MIN);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, -1);
    send_op(OP_LIST, '0);
    send_op(OP_POP_FRONT, VAL_MAX);
    send_op(OP_POP_BACK, VAL_MIN);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, -1);
    send_op(OP_LIST, VAL_MAX);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PUSH_BACK, rand_value());
    send_op(OP_LIST, '0);
    send_op(OP_POP_FRONT, '0);
  endtask

  // fill to capacity, push into a full queue, list, empty it again with lists mixed in, then pop and list it empty
  task automatic test_fill_and_drain();
    while (mirror_fill < DQ_DEPTH) send_op(rand_push(), rand_value());
    send_op(rand_push(), rand_value());
    send_op(rand_push(), rand_value());
    send_op(OP_LIST, rand_value());
    while (mirror_fill != 0) begin
      if ($urandom_range(0, 7) == 0) send_op(OP_LIST, rand_value());
      else send_op(rand_pop(), rand_value());
    end
    send_op(rand_pop(), rand_value());
    send_op(OP_LIST, rand_value());
  endtask

  // weighted random traffic, drifting toward full
  task automatic test_mixed_traffic(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 46) send_op(rand_push(), rand_value());
      else if (r < 82) send_op(rand_pop(), rand_value());
      else if (r < 94) send_op(OP_LIST, rand_value());
      else send_op(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_value());
    end
  endtask

  // no gaps and no stalls
  task automatic test_back_to_back(input int unsigned n);
    quiet = 1'b1;
    test_mixed_traffic(n);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_value_extremes();
    wait_drained();
    test_fill_and_drain();
    test_fill_and_drain();
    test_mixed_traffic(85);
    wait_drained();
    test_back_to_back(30);
    wait_drained();
    repeat (2 * DQ_DEPTH + 8) @(posedge clk_i);
    if (fault_cnt == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
src/dq_pkg.sv
src/dq_mem.sv
src/double_ended_queue.sv
test/double_ended_queue_test.sv
